// ===== sv/iau_pkg.sv =====
// Shared types, widths and constants of the incidence angle unit.
package iau_pkg;

    // Widths after operand limiting and term normalisation.
    localparam int RL_W     = 27;
    localparam int NL_W     = 21;
    localparam int PROD_W   = 48;
    localparam int C_W      = 48;
    localparam int POS_W    = 6;
    localparam int CN_W     = 30;
    localparam int CN_TOP   = 29;
    localparam int SQ_W     = 60;
    localparam int CSQ_W    = 62;
    localparam int ROOT_W   = 31;
    localparam int CX_W     = 34;
    localparam int CZ_W     = 26;
    localparam int ZC_W     = 23;
    localparam int ANGLE_W  = 15;
    localparam int CFG_IDX_W = 2;

    localparam longint RAY_LIM = 64'sd67108864;
    localparam longint NRM_LIM = 64'sd1048576;

    localparam int CORDIC_STEPS = 23;
    localparam logic signed [CZ_W-1:0] FULL_Q16 = 26'sd5898240;

    // Arctangent of 2^-i in degrees, sixteen fraction bits.
    localparam logic signed [CZ_W-1:0] ATAN_DEG [CORDIC_STEPS] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
        26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334,
        26'sd3667, 26'sd1833, 26'sd917, 26'sd458, 26'sd229,
        26'sd115, 26'sd57, 26'sd29, 26'sd14, 26'sd7,
        26'sd4, 26'sd2, 26'sd1
    };

    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_Z = 2'd2;

    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctrl;

endpackage

// ===== sv/iau_front.sv =====
// Front pipeline: ray, operand limiting, cross and dot terms, normalisation, squares.
module iau_front import iau_pkg::*; #(
    parameter int COORD_BITS  = 24,
    parameter int NORMAL_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_ce,
    input  t_ctrl                        i_ctrl,
    input  logic signed [COORD_BITS-1:0] i_point  [3],
    input  logic signed [COORD_BITS-1:0] i_sensor [3],
    input  logic signed [NORMAL_BITS-1:0] i_normal [3],
    output t_ctrl                        o_ctrl,
    output logic [CSQ_W-1:0]             o_csq,
    output logic [CN_W-1:0]              o_dot
);

    localparam int RW = COORD_BITS + 1;

    t_ctrl                        r_s1_ctrl, r_s2_ctrl, r_s3_ctrl, r_s4_ctrl;
    t_ctrl                        r_s5_ctrl, r_s6_ctrl, r_s7_ctrl, r_s8_ctrl, r_s9_ctrl;
    logic signed [RW-1:0]         r_s1_ray [3];
    logic signed [NORMAL_BITS-1:0] r_s1_nrm [3];
    logic signed [RL_W-1:0]       r_s2_ray [3];
    logic signed [NL_W-1:0]       r_s2_nrm [3];
    logic signed [RL_W-1:0]       n_s2_ray [3];
    logic signed [NL_W-1:0]       n_s2_nrm [3];
    logic signed [PROD_W-1:0]     r_s3_prod [9];
    logic [C_W-1:0]               r_s4_c [4];
    logic [C_W-1:0]               n_s4_c [4];
    logic [C_W-1:0]               r_s5_c [4];
    logic [C_W-1:0]               r_s5_m01, r_s5_m23;
    logic [C_W-1:0]               r_s6_c [4];
    logic [POS_W-1:0]             r_s6_pos;
    logic [POS_W-1:0]             n_s6_pos;
    logic                         n_s6_mzero;
    logic [CN_W-1:0]              r_s7_c [4];
    logic [SQ_W-1:0]              r_s8_sq [3];
    logic [CN_W-1:0]              r_s8_dot;
    logic [CSQ_W-1:0]             r_s9_csq;
    logic [CN_W-1:0]              r_s9_dot;

    always_comb begin
        logic ok;
        longint t;
        logic [POS_W-1:0] rs;
        logic [POS_W-1:0] ns;
        rs = '0;
        ns = '0;
        for (int s = COORD_BITS; s >= 0; s--) begin
            ok = 1'b1;
            for (int k = 0; k < 3; k++) begin
                t = longint'(r_s1_ray[k]) >>> s;
                if (t >= RAY_LIM || t <= -RAY_LIM) ok = 1'b0;
            end
            if (ok) rs = POS_W'(s);
        end
        for (int s = NORMAL_BITS; s >= 0; s--) begin
            ok = 1'b1;
            for (int k = 0; k < 3; k++) begin
                t = longint'(r_s1_nrm[k]) >>> s;
                if (t >= NRM_LIM || t <= -NRM_LIM) ok = 1'b0;
            end
            if (ok) ns = POS_W'(s);
        end
        for (int k = 0; k < 3; k++) begin
            t = longint'(r_s1_ray[k]) >>> rs;
            n_s2_ray[k] = t[RL_W-1:0];
            t = longint'(r_s1_nrm[k]) >>> ns;
            n_s2_nrm[k] = t[NL_W-1:0];
        end
    end

    always_comb begin
        logic signed [PROD_W:0] d [4];
        d[0] = (PROD_W+1)'(r_s3_prod[0]) - (PROD_W+1)'(r_s3_prod[1]);
        d[1] = (PROD_W+1)'(r_s3_prod[2]) - (PROD_W+1)'(r_s3_prod[3]);
        d[2] = (PROD_W+1)'(r_s3_prod[4]) - (PROD_W+1)'(r_s3_prod[5]);
        d[3] = (PROD_W+1)'(r_s3_prod[6]) + (PROD_W+1)'(r_s3_prod[7])
             + (PROD_W+1)'(r_s3_prod[8]);
        for (int k = 0; k < 4; k++) begin
            n_s4_c[k] = d[k][PROD_W] ? C_W'(-d[k]) : C_W'(d[k]);
        end
    end

    always_comb begin
        logic [C_W-1:0] m;
        m = (r_s5_m01 > r_s5_m23) ? r_s5_m01 : r_s5_m23;
        n_s6_mzero = (m == '0);
        n_s6_pos = '0;
        for (int i = 0; i < C_W; i++) begin
            if (m[i]) n_s6_pos = POS_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctrl <= '0;
            r_s2_ctrl <= '0;
            r_s3_ctrl <= '0;
            r_s4_ctrl <= '0;
            r_s5_ctrl <= '0;
            r_s6_ctrl <= '0;
            r_s7_ctrl <= '0;
            r_s8_ctrl <= '0;
            r_s9_ctrl <= '0;
        end else if (i_ce) begin
            r_s1_ctrl.valid <= i_ctrl.valid;
            r_s1_ctrl.zero  <= (i_point[0] == i_sensor[0] && i_point[1] == i_sensor[1]
                                && i_point[2] == i_sensor[2])
                               || (i_normal[0] == '0 && i_normal[1] == '0
                                   && i_normal[2] == '0);
            r_s2_ctrl <= r_s1_ctrl;
            r_s3_ctrl <= r_s2_ctrl;
            r_s4_ctrl <= r_s3_ctrl;
            r_s5_ctrl <= r_s4_ctrl;
            r_s6_ctrl.valid <= r_s5_ctrl.valid;
            r_s6_ctrl.zero  <= r_s5_ctrl.zero || n_s6_mzero;
            r_s7_ctrl <= r_s6_ctrl;
            r_s8_ctrl <= r_s7_ctrl;
            r_s9_ctrl <= r_s8_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 3; k++) begin
                r_s1_ray[k] <= RW'(i_point[k]) - RW'(i_sensor[k]);
                r_s1_nrm[k] <= i_normal[k];
                r_s2_ray[k] <= n_s2_ray[k];
                r_s2_nrm[k] <= n_s2_nrm[k];
            end
            r_s3_prod[0] <= PROD_W'(r_s2_ray[1]) * PROD_W'(r_s2_nrm[2]);
            r_s3_prod[1] <= PROD_W'(r_s2_ray[2]) * PROD_W'(r_s2_nrm[1]);
            r_s3_prod[2] <= PROD_W'(r_s2_ray[2]) * PROD_W'(r_s2_nrm[0]);
            r_s3_prod[3] <= PROD_W'(r_s2_ray[0]) * PROD_W'(r_s2_nrm[2]);
            r_s3_prod[4] <= PROD_W'(r_s2_ray[0]) * PROD_W'(r_s2_nrm[1]);
            r_s3_prod[5] <= PROD_W'(r_s2_ray[1]) * PROD_W'(r_s2_nrm[0]);
            r_s3_prod[6] <= PROD_W'(r_s2_ray[0]) * PROD_W'(r_s2_nrm[0]);
            r_s3_prod[7] <= PROD_W'(r_s2_ray[1]) * PROD_W'(r_s2_nrm[1]);
            r_s3_prod[8] <= PROD_W'(r_s2_ray[2]) * PROD_W'(r_s2_nrm[2]);
            r_s4_c   <= n_s4_c;
            r_s5_c   <= r_s4_c;
            r_s5_m01 <= (r_s4_c[0] > r_s4_c[1]) ? r_s4_c[0] : r_s4_c[1];
            r_s5_m23 <= (r_s4_c[2] > r_s4_c[3]) ? r_s4_c[2] : r_s4_c[3];
            r_s6_c   <= r_s5_c;
            r_s6_pos <= n_s6_pos;
            for (int k = 0; k < 4; k++) begin
                if (r_s6_pos > POS_W'(CN_TOP)) begin
                    r_s7_c[k] <= CN_W'(r_s6_c[k] >> (r_s6_pos - POS_W'(CN_TOP)));
                end else begin
                    r_s7_c[k] <= CN_W'(r_s6_c[k] << (POS_W'(CN_TOP) - r_s6_pos));
                end
            end
            for (int k = 0; k < 3; k++) begin
                r_s8_sq[k] <= SQ_W'(r_s7_c[k]) * SQ_W'(r_s7_c[k]);
            end
            r_s8_dot <= r_s7_c[3];
            r_s9_csq <= CSQ_W'(r_s8_sq[0]) + CSQ_W'(r_s8_sq[1]) + CSQ_W'(r_s8_sq[2]);
            r_s9_dot <= r_s8_dot;
        end
    end

    assign o_ctrl = r_s9_ctrl;
    assign o_csq  = r_s9_csq;
    assign o_dot  = r_s9_dot;

endmodule

// ===== sv/iau_sqrt_cell.sv =====
// One cell of the square root chain: decides one bit of the root.
module iau_sqrt_cell import iau_pkg::*; #(
    parameter int K = 30
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ce,
    input  t_ctrl             i_ctrl,
    input  logic [CSQ_W-1:0]  i_rem,
    input  logic [ROOT_W-1:0] i_root,
    input  logic [CN_W-1:0]   i_dot,
    output t_ctrl             o_ctrl,
    output logic [CSQ_W-1:0]  o_rem,
    output logic [ROOT_W-1:0] o_root,
    output logic [CN_W-1:0]   o_dot
);

    t_ctrl             r_ctrl;
    logic [CSQ_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [CN_W-1:0]   r_dot;

    always_comb begin
        logic [63:0] trial;
        trial = (64'(i_root) << (K + 1)) + (64'd1 << (2 * K));
        if (64'(i_rem) >= trial) begin
            n_rem  = CSQ_W'(64'(i_rem) - trial);
            n_root = i_root | (ROOT_W'(1) << K);
        end else begin
            n_rem  = i_rem;
            n_root = i_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_ce) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_dot  <= i_dot;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_dot  = r_dot;

endmodule

// ===== sv/iau_cordic_cell.sv =====
// One vectoring rotation of the angle chain.
module iau_cordic_cell import iau_pkg::*; #(
    parameter int I = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_ce,
    input  t_ctrl                  i_ctrl,
    input  logic signed [CX_W-1:0] i_x,
    input  logic signed [CX_W-1:0] i_y,
    input  logic signed [CZ_W-1:0] i_z,
    output t_ctrl                  o_ctrl,
    output logic signed [CX_W-1:0] o_x,
    output logic signed [CX_W-1:0] o_y,
    output logic signed [CZ_W-1:0] o_z
);

    t_ctrl                  r_ctrl;
    logic signed [CX_W-1:0] r_x, r_y, n_x, n_y;
    logic signed [CZ_W-1:0] r_z, n_z;

    always_comb begin
        logic signed [CX_W-1:0] xs;
        logic signed [CX_W-1:0] ys;
        xs = i_x >>> I;
        ys = i_y >>> I;
        if (i_y > 0) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN_DEG[I];
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN_DEG[I];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_ce) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

// ===== sv/incidence_angle_unit.sv =====
// Top level of the incidence angle unit.
//
// Each input transaction on the slave stream carries one point and one surface
// normal; the unit returns one master transaction with the angle between the
// ray from the configured sensor position to the point and the normal, folded
// into 0 to 90 degrees, plus a flag in tuser when either vector is zero.
// The user must write the sensor position through the configuration port
// only while idle; the unit does not enforce this. The datapath is a fixed
// chain of 9 front stages, 31 square root cells, 23 rotation cells and
// the output register, and takes one transaction per cycle unless stalled.
// Reset clears the sensor position and empties the pipeline and output.
// When the receiver stalls, the output register holds its result and one
// further result is caught in a skid register; tready on the slave side then
// drops and the whole chain holds until the skid register drains.
module incidence_angle_unit import iau_pkg::*; #(
    parameter int COORD_BITS       = 24,
    parameter int NORMAL_FRAC_BITS = 14,
    parameter int ANGLE_FRAC_BITS  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                i_cfg_idx,
    input  logic [COORD_BITS-1:0]               i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // point_x, point_y, point_z, surf_nx, surf_ny, surf_nz
    input  logic [((3*COORD_BITS+3*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // angle
    output logic [15:0]                         o_m_tdata,
    // zero_length
    output logic [0:0]                          o_m_tuser
);

    localparam int NB = NORMAL_FRAC_BITS + 2;
    localparam int SH = 16 - ANGLE_FRAC_BITS;
    localparam logic [31:0] ROUND    = (SH > 0) ? (32'd1 << (SH - 1)) : 32'd0;
    localparam logic [31:0] ANG_FULL = 32'd90 << ANGLE_FRAC_BITS;

    logic signed [COORD_BITS-1:0] r_sensor [3];
    logic signed [COORD_BITS-1:0] w_point  [3];
    logic signed [NB-1:0]         w_normal [3];
    logic                         w_ce;
    t_ctrl                        w_in_ctrl;

    t_ctrl              w_sq_ctrl [ROOT_W+1];
    logic [CSQ_W-1:0]   w_sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]  w_sq_root [ROOT_W+1];
    logic [CN_W-1:0]    w_sq_dot  [ROOT_W+1];

    t_ctrl                  w_cd_ctrl [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] w_cd_x    [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] w_cd_y    [CORDIC_STEPS+1];
    logic signed [CZ_W-1:0] w_cd_z    [CORDIC_STEPS+1];

    logic [ANGLE_W-1:0] w_angle;
    logic               w_push;
    logic               r_out_valid, r_skid_valid;
    logic [ANGLE_W-1:0] r_out_angle, r_skid_angle;
    logic               r_out_zero, r_skid_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor[0] <= '0;
            r_sensor[1] <= '0;
            r_sensor[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SENSOR_X: r_sensor[0] <= i_cfg_data;
                REG_SENSOR_Y: r_sensor[1] <= i_cfg_data;
                REG_SENSOR_Z: r_sensor[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_point[k]  = i_s_tdata[k*COORD_BITS +: COORD_BITS];
            w_normal[k] = i_s_tdata[3*COORD_BITS + k*NB +: NB];
        end
    end

    assign w_ce            = ~r_skid_valid;
    assign o_s_tready      = w_ce;
    assign w_in_ctrl.valid = i_s_tvalid;
    assign w_in_ctrl.zero  = 1'b0;

    iau_front #(
        .COORD_BITS  (COORD_BITS),
        .NORMAL_BITS (NB)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (w_ce),
        .i_ctrl   (w_in_ctrl),
        .i_point  (w_point),
        .i_sensor (r_sensor),
        .i_normal (w_normal),
        .o_ctrl   (w_sq_ctrl[0]),
        .o_csq    (w_sq_rem[0]),
        .o_dot    (w_sq_dot[0])
    );

    assign w_sq_root[0] = '0;

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        iau_sqrt_cell #(
            .K (ROOT_W - 1 - j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_ctrl  (w_sq_ctrl[j]),
            .i_rem   (w_sq_rem[j]),
            .i_root  (w_sq_root[j]),
            .i_dot   (w_sq_dot[j]),
            .o_ctrl  (w_sq_ctrl[j+1]),
            .o_rem   (w_sq_rem[j+1]),
            .o_root  (w_sq_root[j+1]),
            .o_dot   (w_sq_dot[j+1])
        );
    end

    assign w_cd_ctrl[0] = w_sq_ctrl[ROOT_W];
    assign w_cd_x[0]    = CX_W'(w_sq_dot[ROOT_W]);
    assign w_cd_y[0]    = CX_W'(w_sq_root[ROOT_W]);
    assign w_cd_z[0]    = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        iau_cordic_cell #(
            .I (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_ctrl  (w_cd_ctrl[i]),
            .i_x     (w_cd_x[i]),
            .i_y     (w_cd_y[i]),
            .i_z     (w_cd_z[i]),
            .o_ctrl  (w_cd_ctrl[i+1]),
            .o_x     (w_cd_x[i+1]),
            .o_y     (w_cd_y[i+1]),
            .o_z     (w_cd_z[i+1])
        );
    end

    always_comb begin
        logic signed [CZ_W-1:0] z;
        logic [ZC_W-1:0]        zc;
        logic [31:0]            rnd;
        z = w_cd_z[CORDIC_STEPS];
        if (z < 0) begin
            zc = '0;
        end else if (z > FULL_Q16) begin
            zc = FULL_Q16[ZC_W-1:0];
        end else begin
            zc = z[ZC_W-1:0];
        end
        rnd = (32'(zc) + ROUND) >> SH;
        if (rnd > ANG_FULL) rnd = ANG_FULL;
        if (w_cd_ctrl[CORDIC_STEPS].zero) rnd = ANG_FULL;
        w_angle = rnd[ANGLE_W-1:0];
    end

    assign w_push = w_ce && w_cd_ctrl[CORDIC_STEPS].valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_m_tready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_m_tready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_angle <= r_skid_angle;
                r_out_zero  <= r_skid_zero;
            end else begin
                r_out_angle <= w_angle;
                r_out_zero  <= w_cd_ctrl[CORDIC_STEPS].zero;
            end
        end else if (w_push) begin
            r_skid_angle <= w_angle;
            r_skid_zero  <= w_cd_ctrl[CORDIC_STEPS].zero;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_angle};
    assign o_m_tuser  = r_out_zero;

endmodule

// ===== sv/iau_checker.sv =====
// Port-level checker for the incidence angle unit, with its bind statement.
module iau_checker #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [0:0]  o_m_tuser
);

    localparam logic [31:0] ANG_FULL = 32'd90 << ANGLE_FRAC_BITS;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled transaction changed");

    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[14:0] == ANG_FULL[14:0])
        else $error("zero-length result without right angle");

    a_skid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input held off while output register empty");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[15] == 1'b0)
        else $error("padding bit set");

endmodule

bind incidence_angle_unit iau_checker #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_iau_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
